@@ rtl/ppf_pkg.sv @@
package ppf_pkg;

    // Field widths
    localparam int DATA_W      = 16;
    localparam int ID_W        = 8;
    localparam int IDX_OUT_W   = 10;
    localparam int AREA_W      = 27;
    localparam int AMP_W       = 17;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 112;

    // Defaults
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam logic [DATA_W-1:0] THR_RESET = 16'd100;

    // Area saturation limits
    localparam int AREA_MAX = 67108863;
    localparam int AREA_MIN = -67108864;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic clear;
        logic valid;
    } t_acc_ctl;

endpackage

@@ rtl/ppf_div.sv @@
module ppf_div #(
    parameter int DW = 16,
    parameter int VW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient,
    output logic [VW-1:0] o_remainder
);

    localparam int SC_W = $clog2(DW + 1);

    logic            r_busy;
    logic [SC_W-1:0] r_cnt;
    logic [DW-1:0]   r_quo;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;
    logic [VW:0]     shifted;
    logic [VW:0]     trial;

    // One restoring step: shift in the next dividend bit, try the subtract
    assign shifted = {r_rem, r_quo[DW-1]};
    assign trial   = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= SC_W'(DW);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy && r_cnt != '0) begin
            if (!trial[VW]) begin
                r_rem <= trial[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_busy && (r_cnt == '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ rtl/ppf_store.sv @@
module ppf_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ppf_pkg::DATA_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [ppf_pkg::DATA_W-1:0] o_rdata
);

    logic [ppf_pkg::DATA_W-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

@@ rtl/ppf_base.sv @@
module ppf_base #(
    parameter int CW = 11
) (
    input  logic                       i_clk,
    input  logic                       i_init,
    input  logic                       i_step,
    input  logic [CW-1:0]              i_n,
    input  logic [ppf_pkg::DATA_W-1:0] i_k,
    input  logic [CW-1:0]              i_rem,
    input  logic [ppf_pkg::DATA_W-1:0] i_first,
    input  logic                       i_neg,
    output logic [ppf_pkg::DATA_W-1:0] o_baseline
);

    // Tracks (2*i*|D| + N) as r_q*(2N) + r_r; r_q is the rounded offset
    logic [ppf_pkg::DATA_W-1:0] r_q;
    logic [CW:0]                r_r;
    logic [CW:0]                two_n;
    logic [CW:0]                m;
    logic [CW+1:0]              r_sum;
    logic                       wrap;

    assign two_n = {i_n, 1'b0};
    assign m     = {i_rem, 1'b0};
    assign r_sum = {1'b0, r_r} + {1'b0, m};
    assign wrap  = r_sum >= {1'b0, two_n};

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_q <= '0;
            r_r <= {1'b0, i_n};
        end else if (i_step) begin
            if (wrap) begin
                r_q <= r_q + i_k + 1'b1;
                r_r <= (CW+1)'(r_sum - {1'b0, two_n});
            end else begin
                r_q <= r_q + i_k;
                r_r <= r_sum[CW:0];
            end
        end
    end

    assign o_baseline = i_neg ? (i_first - r_q) : (i_first + r_q);

endmodule

@@ rtl/ppf_accum.sv @@
module ppf_accum #(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic                          i_clk,
    input  ppf_pkg::t_acc_ctl             i_ctl,
    input  logic [AW-1:0]                 i_idx,
    input  logic [ppf_pkg::DATA_W-1:0]    i_x,
    input  logic [ppf_pkg::DATA_W-1:0]    i_b,
    input  logic [ppf_pkg::DATA_W-1:0]    i_thr,
    output logic [ppf_pkg::AREA_W-1:0]    o_area,
    output logic [ppf_pkg::DATA_W-1:0]    o_level,
    output logic [ppf_pkg::IDX_OUT_W-1:0] o_pidx,
    output logic [ppf_pkg::DATA_W-1:0]    o_bkg,
    output logic [ppf_pkg::AMP_W-1:0]     o_amp,
    output logic                          o_pfound,
    output logic [ppf_pkg::IDX_OUT_W-1:0] o_cidx,
    output logic                          o_cfound
);

    localparam int DW    = ppf_pkg::DATA_W;
    localparam int ACC_W = DW + 1 + CW;
    localparam int SW    = ((ACC_W > ppf_pkg::AREA_W) ? ACC_W : ppf_pkg::AREA_W) + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'(ppf_pkg::AREA_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(ppf_pkg::AREA_MIN);

    logic signed [ACC_W-1:0] r_area;
    logic [DW-1:0]           r_level;
    logic [DW-1:0]           r_bkg;
    logic [AW-1:0]           r_pidx;
    logic                    r_pfound;
    logic [AW-1:0]           r_cidx;
    logic                    r_cfound;
    logic signed [DW:0]      diff;
    logic                    above_thr;
    logic signed [SW-1:0]    area_ext;

    assign diff      = $signed({1'b0, i_x}) - $signed({1'b0, i_b});
    assign above_thr = {2'b00, i_x} > ({2'b00, i_b} + {2'b00, i_thr});

    // Per-sample update of area, peak and crossing
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_area   <= '0;
            r_level  <= '0;
            r_bkg    <= '0;
            r_pidx   <= '0;
            r_pfound <= 1'b0;
            r_cidx   <= '0;
            r_cfound <= 1'b0;
        end else if (i_ctl.valid) begin
            r_area <= r_area + ACC_W'(diff);
            if (i_x > r_level) begin
                r_level  <= i_x;
                r_bkg    <= i_b;
                r_pidx   <= i_idx;
                r_pfound <= 1'b1;
            end
            if (!r_cfound && above_thr) begin
                r_cfound <= 1'b1;
                r_cidx   <= i_idx;
            end
        end
    end

    // Saturate area to the output range
    assign area_ext = SW'(r_area);
    always_comb begin
        if (area_ext > SAT_HI) begin
            o_area = ppf_pkg::AREA_W'(SAT_HI);
        end else if (area_ext < SAT_LO) begin
            o_area = ppf_pkg::AREA_W'(SAT_LO);
        end else begin
            o_area = ppf_pkg::AREA_W'(area_ext);
        end
    end

    assign o_level  = r_level;
    assign o_bkg    = r_bkg;
    assign o_pidx   = ppf_pkg::IDX_OUT_W'(r_pidx);
    assign o_amp    = ppf_pkg::AMP_W'($signed({1'b0, r_level}) - $signed({1'b0, r_bkg}));
    assign o_pfound = r_pfound;
    assign o_cidx   = ppf_pkg::IDX_OUT_W'(r_cidx);
    assign o_cfound = r_cfound;

endmodule

@@ rtl/pulse_peak_finder_linear_baseline.sv @@
// Samples are taken one per cycle while collecting; the transaction carrying tlast ends the run.
// After tlast the block is busy (N = stored samples): a setup state,
// a 16-step divider for |last - first| / N, then one store read per sample.
// A result held at the output stalls the next one.
// The result waits in an output register; collection of the next run goes on meanwhile.
// Synchronous active-low reset clears control state and loads the threshold to 100.
module pulse_peak_finder_linear_baseline #(
    parameter int MAX_SAMPLES = ppf_pkg::MAX_SAMPLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: sample[15:0], run_id[23:16]
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [ppf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    // tdata: run_tag[7:0], peak_area[34:8], peak_level[50:35], peak_index[60:51],
    // background_level[76:61], peak_amplitude[93:77], peak_found[94],
    // crossing_index[104:95], crossing_found[105], length_overflow[106], zero[111:107]
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [ppf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // threshold_level write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ppf_pkg::DATA_W-1:0]         i_cfg_data
);

    localparam int DW = ppf_pkg::DATA_W;
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_PREP    = 3'd1;
    localparam logic [2:0] S_DIV     = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_DRAIN   = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]                        r_state;
    logic [CW-1:0]                     r_count;
    logic                              r_ovf;
    logic [ppf_pkg::ID_W-1:0]          r_id;
    logic [DW-1:0]                     r_first;
    logic [DW-1:0]                     r_last;
    logic [DW-1:0]                     r_thr;
    logic [AW-1:0]                     r_idx;
    logic                              r_pv;
    logic [AW-1:0]                     r_pidx;
    logic [DW-1:0]                     r_pb;
    logic                              r_out_valid;
    logic [ppf_pkg::OUT_TDATA_W-1:0]   r_out_data;

    logic                              s_acc;
    logic [DW-1:0]                     s_sample;
    logic                              store_we;
    logic                              full;
    logic                              neg;
    logic [DW-1:0]                     mag;
    logic                              div_start;
    logic                              div_done;
    logic [DW-1:0]                     quot;
    logic [CW-1:0]                     rem;
    logic                              base_init;
    logic                              scan_step;
    logic [DW-1:0]                     baseline;
    logic [DW-1:0]                     rd_data;
    logic                              out_load;
    logic                              last_idx;
    ppf_pkg::t_acc_ctl                 acc_ctl;

    logic [ppf_pkg::AREA_W-1:0]        a_area;
    logic [DW-1:0]                     a_level;
    logic [ppf_pkg::IDX_OUT_W-1:0]     a_pidx;
    logic [DW-1:0]                     a_bkg;
    logic [ppf_pkg::AMP_W-1:0]         a_amp;
    logic                              a_pfound;
    logic [ppf_pkg::IDX_OUT_W-1:0]     a_cidx;
    logic                              a_cfound;

    // Handshakes and sequencer strobes
    assign o_s_axis_tready = (r_state == S_COLLECT);
    assign o_cfg_ready     = 1'b1;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign s_sample        = i_s_axis_tdata[DW-1:0];
    assign full            = (r_count == CW'(MAX_SAMPLES));
    assign store_we        = s_acc && !full;
    assign neg             = r_last < r_first;
    assign mag             = neg ? (r_first - r_last) : (r_last - r_first);
    assign div_start       = (r_state == S_PREP);
    assign base_init       = (r_state == S_DIV) && div_done;
    assign scan_step       = (r_state == S_SCAN);
    assign last_idx        = (CW'(r_idx) == r_count - 1'b1);
    assign out_load        = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);
    assign acc_ctl.clear   = base_init;
    assign acc_ctl.valid   = r_pv;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ppf_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // Sequencer and run bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_id    <= '0;
            r_idx   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_pv <= 1'b0;
            case (r_state)
                S_COLLECT: begin
                    if (s_acc) begin
                        if (r_count == '0 && !r_ovf) begin
                            r_id <= i_s_axis_tdata[ppf_pkg::IN_TDATA_W-1:DW];
                        end
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pv  <= 1'b1;
                    r_idx <= r_idx + 1'b1;
                    if (last_idx) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_COLLECT;
                    end
                end
                default: begin
                    r_state <= S_COLLECT;
                end
            endcase
        end
    end

    // First and last stored sample, scan pipeline payload
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            if (r_count == '0) begin
                r_first <= s_sample;
            end
            r_last <= s_sample;
        end
        if (scan_step) begin
            r_pidx <= r_idx;
            r_pb   <= baseline;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {5'b0, r_ovf, a_cfound, a_cidx, a_pfound, a_amp, a_bkg,
                           a_pidx, a_level, a_area, r_id};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    ppf_store #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (s_sample),
        .i_re    (scan_step),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    ppf_div #(
        .DW (DW),
        .VW (CW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (mag),
        .i_divisor   (r_count),
        .o_done      (div_done),
        .o_quotient  (quot),
        .o_remainder (rem)
    );

    ppf_base #(
        .CW (CW)
    ) u_base (
        .i_clk      (i_clk),
        .i_init     (base_init),
        .i_step     (scan_step),
        .i_n        (r_count),
        .i_k        (quot),
        .i_rem      (rem),
        .i_first    (r_first),
        .i_neg      (neg),
        .o_baseline (baseline)
    );

    ppf_accum #(
        .AW (AW),
        .CW (CW)
    ) u_accum (
        .i_clk    (i_clk),
        .i_ctl    (acc_ctl),
        .i_idx    (r_pidx),
        .i_x      (rd_data),
        .i_b      (r_pb),
        .i_thr    (r_thr),
        .o_area   (a_area),
        .o_level  (a_level),
        .o_pidx   (a_pidx),
        .o_bkg    (a_bkg),
        .o_amp    (a_amp),
        .o_pfound (a_pfound),
        .o_cidx   (a_cidx),
        .o_cfound (a_cfound)
    );

    // Store fill never passes its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    // Dropped samples only happen with a full store
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow flag without full store");

    // Analysis always has at least one stored sample
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_count != '0)
        else $error("analysis started on an empty run");

    // Scan reads stay inside the samples of this run
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_step |-> CW'(r_idx) < r_count)
        else $error("scan index beyond stored samples");

    // Divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider done outside divide wait");

    // Scan hands over to drain right after its last index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_step && last_idx |=> r_state == S_DRAIN)
        else $error("scan did not end on its last index");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int                 DATA_W      = ppf_pkg::DATA_W;
    localparam int                 ID_W        = ppf_pkg::ID_W;
    localparam int                 IDX_OUT_W   = ppf_pkg::IDX_OUT_W;
    localparam int                 AREA_W      = ppf_pkg::AREA_W;
    localparam int                 AMP_W       = ppf_pkg::AMP_W;
    localparam int                 IN_TDATA_W  = ppf_pkg::IN_TDATA_W;
    localparam int                 OUT_TDATA_W = ppf_pkg::OUT_TDATA_W;
    localparam logic [DATA_W-1:0]  THR_RESET   = ppf_pkg::THR_RESET;
    localparam int                 AREA_MAX    = ppf_pkg::AREA_MAX;
    localparam int                 AREA_MIN    = ppf_pkg::AREA_MIN;

    localparam int STORE_DEPTH    = ppf_pkg::MAX_SAMPLES_DEF;
    localparam int GAP_MAX        = 15;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int FINAL_CYCLES   = 2 * STORE_DEPTH + 40;
    localparam int RANDOM_ITEMS   = 800;
    localparam int HOLD_CYCLES    = 3000;
    localparam int MAX_REPORTED   = 10;
    localparam int DROPPED_EXTRA  = 6;

    // Sample shapes used to build runs
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_PULSE,
        SHAPE_ZERO,
        SHAPE_RAIL
    } t_shape;

    // Result layout, first member in the top bits, run_tag in the lowest bits
    typedef struct packed {
        logic [4:0]           pad;
        logic                 ovf;
        logic                 cross_found;
        logic [IDX_OUT_W-1:0] cross_idx;
        logic                 pk_found;
        logic [AMP_W-1:0]     amplitude;
        logic [DATA_W-1:0]    background;
        logic [IDX_OUT_W-1:0] pk_idx;
        logic [DATA_W-1:0]    pk_level;
        logic [AREA_W-1:0]    area;
        logic [ID_W-1:0]      tag;
    } t_pulse_report;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;   // sample[15:0], run_id[23:16]
    logic                   i_s_axis_tlast  = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;         // run_tag[7:0] ... length_overflow[106]
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic [DATA_W-1:0]      i_cfg_data      = '0;

    // Predictor state
    logic [DATA_W-1:0] run_buf [STORE_DEPTH];
    int                run_len     = 0;
    logic [ID_W-1:0]   run_tag     = '0;
    bit                run_dropped = 1'b0;
    logic [DATA_W-1:0] thr_level   = THR_RESET;
    t_pulse_report     pending_reports[$];
    logic [DATA_W-1:0] staged[$];

    // Bookkeeping
    int  error_count      = 0;
    int  reports_checked  = 0;
    int  samples_accepted = 0;
    int  runs_closed      = 0;
    int  overflow_runs    = 0;
    int  crossing_runs    = 0;
    int  empty_runs       = 0;
    int  stall_cycles     = 0;
    int  sink_hold        = 0;
    bit  idle_on          = 1'b1;

    pulse_peak_finder_linear_baseline dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Integer division rounded half away from zero, den >= 1
    function automatic longint round_half_away(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    // Store one accepted sample; on the closing sample analyse the run
    function automatic void absorb_sample(logic [DATA_W-1:0] s, logic [ID_W-1:0] id, bit last);
        longint first, span, area, x, b, level, bkg, amp;
        int pidx, cidx;
        bit pfound, cfound;
        t_pulse_report r;
        if (run_len == 0 && !run_dropped)
            run_tag = id;
        if (run_len < STORE_DEPTH) begin
            run_buf[run_len] = s;
            run_len++;
        end else begin
            run_dropped = 1'b1;
        end
        if (!last)
            return;

        first  = run_buf[0];
        span   = longint'(run_buf[run_len-1]) - first;
        area   = 0;
        level  = 0;
        bkg    = 0;
        pidx   = 0;
        cidx   = 0;
        pfound = 1'b0;
        cfound = 1'b0;
        for (int i = 0; i < run_len; i++) begin
            x = run_buf[i];
            b = first + round_half_away(longint'(i) * span, longint'(run_len));
            area += x - b;
            // first strictly highest sample wins
            if (x > level) begin
                level  = x;
                bkg    = b;
                pidx   = i;
                pfound = 1'b1;
            end
            if (!cfound && x > b + longint'(thr_level)) begin
                cfound = 1'b1;
                cidx   = i;
            end
        end
        if (area > AREA_MAX)
            area = AREA_MAX;
        if (area < AREA_MIN)
            area = AREA_MIN;
        amp = level - bkg;

        r.pad         = '0;
        r.tag         = run_tag;
        r.area        = area[AREA_W-1:0];
        r.pk_level    = level[DATA_W-1:0];
        r.pk_idx      = pidx[IDX_OUT_W-1:0];
        r.background  = bkg[DATA_W-1:0];
        r.amplitude   = amp[AMP_W-1:0];
        r.pk_found    = pfound;
        r.cross_idx   = cidx[IDX_OUT_W-1:0];
        r.cross_found = cfound;
        r.ovf         = run_dropped;
        pending_reports.push_back(r);

        runs_closed++;
        if (run_dropped)
            overflow_runs++;
        if (cfound)
            crossing_runs++;
        if (!pfound)
            empty_runs++;
        run_len     = 0;
        run_dropped = 1'b0;
    endfunction

    function automatic void report_field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTED)
                $display("MISMATCH result %0d %s: expected %h, got %h",
                         reports_checked, name, want, got);
        end
    endfunction

    // Compare every result transaction with the oldest prediction
    always @(posedge i_clk) begin : report_check
        t_pulse_report got;
        t_pulse_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (pending_reports.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTED)
                    $display("MISMATCH unexpected result, tdata %h", o_m_axis_tdata);
            end else begin
                want = pending_reports.pop_front();
                report_field_diff("run_tag", 32'(want.tag), 32'(got.tag));
                report_field_diff("peak_area", 32'(want.area), 32'(got.area));
                report_field_diff("peak_level", 32'(want.pk_level), 32'(got.pk_level));
                report_field_diff("peak_index", 32'(want.pk_idx), 32'(got.pk_idx));
                report_field_diff("background_level", 32'(want.background),
                                  32'(got.background));
                report_field_diff("peak_amplitude", 32'(want.amplitude), 32'(got.amplitude));
                report_field_diff("peak_found", 32'(want.pk_found), 32'(got.pk_found));
                report_field_diff("crossing_index", 32'(want.cross_idx), 32'(got.cross_idx));
                report_field_diff("crossing_found", 32'(want.cross_found),
                                  32'(got.cross_found));
                report_field_diff("length_overflow", 32'(want.ovf), 32'(got.ovf));
                report_field_diff("pad", 32'(want.pad), 32'(got.pad));
                reports_checked++;
            end
        end
    end

    // Result side: random stall after each transaction while idle gaps are on, long hold on request
    initial begin : result_sink
        int gap;
        while (!i_rst_n)
            @(posedge i_clk);
        i_m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            gap = 0;
            if (sink_hold > 0) begin
                gap       = sink_hold;
                sink_hold = 0;
            end else if (i_m_axis_tready && o_m_axis_tvalid && idle_on) begin
                gap = $urandom_range(0, GAP_MAX);
            end
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Cycles without any transaction
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT: no transaction for %0d cycles", stall_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    // One sample transaction, with a random gap in front of it while idle gaps are on
    task automatic send_sample(logic [DATA_W-1:0] s, logic [ID_W-1:0] id, bit last);
        int gap;
        gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= {id, s};
        i_s_axis_tlast  <= last;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        samples_accepted++;
        absorb_sample(s, id, last);
    endtask

    // Stop offering samples and wait until every result has been checked
    task automatic drain_reports(int settle);
        i_s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Only called with the block idle
    task automatic write_threshold(logic [DATA_W-1:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        thr_level = value;
    endtask

    // Send the staged values as one run; later samples carry stray ids
    task automatic send_staged(logic [ID_W-1:0] id);
        for (int i = 0; i < staged.size(); i++)
            send_sample(staged[i], (i == 0) ? id : ID_W'($urandom), i == staged.size() - 1);
    endtask

    task automatic send_run(int len, t_shape shape, logic [ID_W-1:0] id);
        int base, height, peak_at, v;
        logic [DATA_W-1:0] s;
        base    = $urandom_range(0, 65535);
        height  = $urandom_range(0, 20000);
        peak_at = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_NOISE: begin
                    s = DATA_W'($urandom);
                end
                SHAPE_PULSE: begin
                    v = base + $urandom_range(0, 31);
                    if (i == peak_at)
                        v += height;
                    else if (i == peak_at + 1 || i + 1 == peak_at)
                        v += height / 2;
                    s = (v > 65535) ? 16'hFFFF : DATA_W'(v);
                end
                SHAPE_ZERO: begin
                    s = '0;
                end
                default: begin
                    s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
            endcase
            send_sample(s, (i == 0) ? id : ID_W'($urandom), i == len - 1);
        end
    endtask

    function automatic t_shape pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return SHAPE_PULSE;
        if (r < 80)
            return SHAPE_NOISE;
        if (r < 90)
            return SHAPE_ZERO;
        return SHAPE_RAIL;
    endfunction

    // Short runs with the reset threshold: rounding, ties, boundaries
    task automatic test_directed_shapes();
        staged = {16'hFFFF};
        send_staged(8'hFF);
        staged = {16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        send_staged(8'h00);
        staged = {16'd10, 16'd500, 16'd500, 16'd20};
        send_staged(8'hA5);
        staged = {16'd100, 16'd0, 16'd300, 16'd98};
        send_staged(8'h5A);
        staged = {16'd0, 16'hFFFF, 16'd0, 16'd2};
        send_staged(8'h3C);
        staged = {16'd50, 16'd150, 16'd151, 16'd50};
        send_staged(8'hC3);
        staged = {16'hFFFF, 16'd0, 16'd0, 16'd0};
        send_staged(8'h81);
        drain_reports(SETTLE_CYCLES);
    endtask

    // One run that fills the store with its largest area, then overflows it
    task automatic test_store_limits();
        idle_on = 1'b0;
        staged = {};
        staged.push_back(16'd0);
        for (int i = 0; i < STORE_DEPTH - 2; i++)
            staged.push_back(16'hFFFF);
        staged.push_back(16'd0);
        for (int i = 0; i < DROPPED_EXTRA; i++)
            staged.push_back(DATA_W'($urandom));
        send_staged(8'h42);
        drain_reports(SETTLE_CYCLES);
        idle_on = 1'b1;
    endtask

    task automatic test_threshold_extremes();
        write_threshold(16'd0);
        staged = {16'd5, 16'd5, 16'd6, 16'd5};
        send_staged(8'h11);
        drain_reports(SETTLE_CYCLES);
        write_threshold(16'hFFFF);
        staged = {16'd0, 16'hFFFF, 16'd0};
        send_staged(8'hEE);
        drain_reports(SETTLE_CYCLES);
    endtask

    // Mostly short runs, a few long ones, under one threshold
    task automatic test_random_runs(int items, logic [DATA_W-1:0] thr, bit with_idle);
        int sent, len, r;
        write_threshold(thr);
        idle_on = with_idle;
        sent = 0;
        while (sent < items) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 12);
            else if (r < 96)
                len = $urandom_range(13, 64);
            else
                len = $urandom_range(65, 300);
            send_run(len, pick_shape(), ID_W'($urandom));
            sent += len;
        end
        drain_reports(SETTLE_CYCLES);
        idle_on = 1'b1;
    endtask

    // Receiver holds off while samples keep coming, then the sender waits it out
    task automatic test_backpressure();
        sink_hold = HOLD_CYCLES;
        for (int k = 0; k < 30; k++)
            send_run($urandom_range(2, 6), SHAPE_PULSE, ID_W'($urandom));
        drain_reports(SETTLE_CYCLES);
        for (int k = 0; k < 5; k++)
            send_run($urandom_range(1, 8), pick_shape(), ID_W'($urandom));
        drain_reports(SETTLE_CYCLES);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_shapes();
        test_store_limits();
        test_threshold_extremes();
        test_random_runs(RANDOM_ITEMS / 4, DATA_W'($urandom), 1'b1);
        test_random_runs(RANDOM_ITEMS / 4, 16'd0, 1'b0);
        test_random_runs(RANDOM_ITEMS / 4, DATA_W'($urandom_range(0, 400)), 1'b1);
        test_random_runs(RANDOM_ITEMS / 4, 16'hFFFF, 1'b1);
        test_backpressure();

        drain_reports(FINAL_CYCLES);
        $display("Checked %0d results from %0d samples in %0d runs", reports_checked,
                 samples_accepted, runs_closed);
        $display("Runs with overflow %0d, with crossing %0d, without peak %0d",
                 overflow_runs, crossing_runs, empty_runs);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ppf_pkg.sv
rtl/ppf_div.sv
rtl/ppf_store.sv
rtl/ppf_base.sv
rtl/ppf_accum.sv
rtl/pulse_peak_finder_linear_baseline.sv
tb/tb.sv
